### hw/rtl/mcsf_pkg.sv
// package for the memory card sector frame engine: types and protocol constants
`default_nettype none

package mcsf_pkg;

    // apb register map
    localparam int unsigned ApbAddrWidth = 3;
    localparam int unsigned ApbDataWidth = 32;
    localparam logic        RegIdxAckCheck = 1'b0;
    localparam logic        AckCheckReset  = 1'b1;

    // stream widths
    localparam int unsigned InDataWidth  = 32;
    localparam int unsigned OutDataWidth = 24;

    // frame types
    localparam logic OpRead  = 1'b0;
    localparam logic OpWrite = 1'b1;

    // slot positions
    localparam logic [7:0] SlotCmd        = 8'd0;
    localparam logic [7:0] SlotKind       = 8'd1;
    localparam logic [7:0] SlotId0        = 8'd2;
    localparam logic [7:0] SlotId1        = 8'd3;
    localparam logic [7:0] SlotSecHi      = 8'd4;
    localparam logic [7:0] SlotSecLo      = 8'd5;
    localparam logic [7:0] SlotRdAck0     = 8'd6;
    localparam logic [7:0] SlotRdAck1     = 8'd7;
    localparam logic [7:0] SlotRdEchoHi   = 8'd8;
    localparam logic [7:0] SlotRdEchoLo   = 8'd9;
    localparam logic [7:0] SlotRdDataLo   = 8'd10;
    localparam logic [7:0] SlotRdDataHi   = 8'd137;
    localparam logic [7:0] SlotRdCsum     = 8'd138;
    localparam logic [7:0] SlotRdLast     = 8'd139;
    localparam logic [7:0] SlotWrDataLo   = 8'd6;
    localparam logic [7:0] SlotWrDataHi   = 8'd133;
    localparam logic [7:0] SlotWrCsum     = 8'd134;
    localparam logic [7:0] SlotWrAck0     = 8'd135;
    localparam logic [7:0] SlotWrAck1     = 8'd136;
    localparam logic [7:0] SlotWrLast     = 8'd137;

    // protocol bytes
    localparam logic [7:0] ByteCmd      = 8'h81;
    localparam logic [7:0] ByteRead     = 8'h52;
    localparam logic [7:0] ByteWrite    = 8'h57;
    localparam logic [7:0] ByteId0      = 8'h5A;
    localparam logic [7:0] ByteId1      = 8'h5D;
    localparam logic [7:0] ByteAck0     = 8'h5C;
    localparam logic [7:0] ByteAck1     = 8'h5D;
    localparam logic [7:0] ByteGood     = 8'h47;
    localparam logic [7:0] ByteBadCsum  = 8'h4E;
    localparam logic [7:0] ByteBadSec   = 8'hFF;

    // frame status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_CARD  = 3'd1,
        ST_NO_ACK   = 3'd2,
        ST_BAD_SEC  = 3'd3,
        ST_BAD_CSUM = 3'd4,
        ST_UNKNOWN  = 3'd5
    } t_status;

    // result of one slot
    typedef struct packed {
        logic [7:0] send_byte;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       frame_done;
        t_status    status;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/mcsf_apb_regs.sv
// apb configuration register: acknowledge check enable
`default_nettype none

module mcsf_apb_regs
    import mcsf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ApbAddrWidth-1:0] paddr,
    input  wire logic [ApbDataWidth-1:0] pwdata,
    output logic      [ApbDataWidth-1:0] prdata,
    output logic                         pready,
    output logic                         o_ack_check_enable
);

    logic r_ack_check;
    logic n_ack_check;
    logic reg_hit;

    // register index from the word address
    assign reg_hit = (paddr[ApbAddrWidth-1] == RegIdxAckCheck);
    assign pready  = 1'b1;

    // write decode
    always_comb begin
        n_ack_check = r_ack_check;
        if (psel && penable && pwrite && reg_hit) begin
            n_ack_check = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_check <= AckCheckReset;
        end else begin
            r_ack_check <= n_ack_check;
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = {{(ApbDataWidth-1){1'b0}}, r_ack_check};
        end
    end

    assign o_ack_check_enable = r_ack_check;

endmodule

`default_nettype wire

### hw/rtl/mcsf_slot_engine.sv
// slot engine: frame state, send byte selection and received byte checks
`default_nettype none

module mcsf_slot_engine
    import mcsf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_ack_check,
    input  wire logic        i_op,
    input  wire logic [15:0] i_expected_sector,
    input  wire logic [7:0]  i_card_byte,
    input  wire logic [7:0]  i_host_byte,
    output t_result          o_result
);

    logic [7:0]  r_pos,  n_pos;
    logic        r_mode, n_mode;
    logic [15:0] r_sector, n_sector;
    logic [7:0]  r_rx_xor, n_rx_xor;
    logic [7:0]  r_tx_xor, n_tx_xor;
    logic [7:0]  r_echo_hi, n_echo_hi;
    t_status     r_ferr, n_ferr;

    logic        base_mode;
    logic [15:0] base_sector;
    logic [7:0]  base_rx_xor;
    logic [7:0]  base_tx_xor;
    logic [7:0]  base_echo_hi;
    t_status     base_ferr;
    logic [7:0]  tx;
    logic [7:0]  last_slot;
    t_status     err;
    logic        done;

    // frame start takes fresh mode and sector and clears the running state
    always_comb begin
        if (r_pos == SlotCmd) begin
            base_mode    = i_op;
            base_sector  = i_expected_sector;
            base_rx_xor  = '0;
            base_tx_xor  = '0;
            base_echo_hi = '0;
            base_ferr    = ST_OK;
        end else begin
            base_mode    = r_mode;
            base_sector  = r_sector;
            base_rx_xor  = r_rx_xor;
            base_tx_xor  = r_tx_xor;
            base_echo_hi = r_echo_hi;
            base_ferr    = r_ferr;
        end
    end

    // byte to send
    always_comb begin
        tx = '0;
        if (r_pos == SlotCmd) begin
            tx = ByteCmd;
        end else if (r_pos == SlotKind) begin
            tx = (base_mode == OpWrite) ? ByteWrite : ByteRead;
        end else if (r_pos == SlotSecHi) begin
            tx = base_sector[15:8];
        end else if (r_pos == SlotSecLo) begin
            tx = base_sector[7:0];
        end else if (base_mode == OpWrite && r_pos >= SlotWrDataLo && r_pos <= SlotWrDataHi) begin
            tx = i_host_byte;
        end else if (base_mode == OpWrite && r_pos == SlotWrCsum) begin
            tx = base_tx_xor;
        end
    end

    // running checksums and echo capture
    always_comb begin
        n_tx_xor  = base_tx_xor;
        n_rx_xor  = base_rx_xor;
        n_echo_hi = base_echo_hi;
        if (base_mode == OpWrite && r_pos >= SlotSecHi && r_pos <= SlotWrDataHi) begin
            n_tx_xor = base_tx_xor ^ tx;
        end
        if (base_mode == OpRead && r_pos >= SlotRdEchoHi && r_pos <= SlotRdCsum) begin
            n_rx_xor = base_rx_xor ^ i_card_byte;
        end
        if (base_mode == OpRead && r_pos == SlotRdEchoHi) begin
            n_echo_hi = i_card_byte;
        end
    end

    // per-slot check, at most one position matches
    always_comb begin
        err = ST_OK;
        if (r_pos == SlotId0 && i_card_byte != ByteId0) begin
            err = ST_NO_CARD;
        end else if (r_pos == SlotId1 && i_card_byte != ByteId1) begin
            err = ST_NO_CARD;
        end else if (base_mode == OpRead) begin
            if (i_ack_check && r_pos == SlotRdAck0 && i_card_byte != ByteAck0) begin
                err = ST_NO_ACK;
            end else if (i_ack_check && r_pos == SlotRdAck1 && i_card_byte != ByteAck1) begin
                err = ST_NO_ACK;
            end else if (r_pos == SlotRdEchoLo && {base_echo_hi, i_card_byte} != base_sector) begin
                err = ST_BAD_SEC;
            end else if (r_pos == SlotRdCsum && n_rx_xor != 8'h00) begin
                err = ST_BAD_CSUM;
            end else if (r_pos == SlotRdLast && i_card_byte != ByteGood) begin
                err = ST_UNKNOWN;
            end
        end else begin
            if (i_ack_check && r_pos == SlotWrAck0 && i_card_byte != ByteAck0) begin
                err = ST_NO_ACK;
            end else if (i_ack_check && r_pos == SlotWrAck1 && i_card_byte != ByteAck1) begin
                err = ST_NO_ACK;
            end else if (r_pos == SlotWrLast) begin
                case (i_card_byte)
                    ByteGood:    err = ST_OK;
                    ByteBadCsum: err = ST_BAD_CSUM;
                    ByteBadSec:  err = ST_BAD_SEC;
                    default:     err = ST_UNKNOWN;
                endcase
            end
        end
    end

    // first error wins, slot counter wraps at the last slot
    always_comb begin
        last_slot = (base_mode == OpWrite) ? SlotWrLast : SlotRdLast;
        done      = (r_pos >= last_slot);
        n_ferr    = (base_ferr == ST_OK) ? err : base_ferr;
        n_pos     = done ? SlotCmd : r_pos + 8'd1;
        n_mode    = base_mode;
        n_sector  = base_sector;
    end

    // result of this slot
    always_comb begin
        o_result.send_byte  = tx;
        o_result.data_valid = (base_mode == OpRead)
                              && (r_pos >= SlotRdDataLo) && (r_pos <= SlotRdDataHi);
        o_result.data_byte  = o_result.data_valid ? i_card_byte : 8'h00;
        o_result.frame_done = done;
        o_result.status     = done ? n_ferr : ST_OK;
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= SlotCmd;
            r_mode    <= OpRead;
            r_sector  <= '0;
            r_rx_xor  <= '0;
            r_tx_xor  <= '0;
            r_echo_hi <= '0;
            r_ferr    <= ST_OK;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_mode    <= n_mode;
            r_sector  <= n_sector;
            r_rx_xor  <= n_rx_xor;
            r_tx_xor  <= n_tx_xor;
            r_echo_hi <= n_echo_hi;
            r_ferr    <= n_ferr;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/memory_card_sector_frame.sv
// top level of the memory card sector frame engine
//
//  channel     | direction | transfer            | content
//  s_axis      | in        | tvalid & tready     | tdata: expected_sector, card_byte, host_byte
//              |           |                     | tuser: op
//  m_axis      | out       | tvalid & tready     | tdata: send_byte, data_byte, status
//              |           |                     | tuser: data_valid, tlast: frame_done
//  apb         | in/out    | psel&penable&pwrite | ack_check_enable at byte address 0
//
// one slot per cycle: a slot is evaluated in the cycle it is accepted and its
// result sits in the output register from the next cycle on
// the output register is refilled in the same cycle it is emptied, so a slot
// is accepted every cycle while the sink takes results
// a stalled sink holds the result and stops intake until it is taken
// synchronous active-low reset returns to slot 0 and sets ack checking on
`default_nettype none

module memory_card_sector_frame
    import mcsf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [InDataWidth-1:0]  s_axis_tdata,  // [15:0] expected_sector,
                                                        // [23:16] card_byte, [31:24] host_byte
    input  wire logic                    s_axis_tuser,  // [0] op
    // output stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic      [OutDataWidth-1:0] m_axis_tdata,  // [7:0] send_byte, [15:8] data_byte,
                                                        // [18:16] status, [23:19] zero
    output logic                         m_axis_tuser,  // [0] data_valid
    output logic                         m_axis_tlast,
    // configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ApbAddrWidth-1:0] paddr,
    input  wire logic [ApbDataWidth-1:0] pwdata,
    output logic      [ApbDataWidth-1:0] prdata,
    output logic                         pready
);

    logic    ack_check;
    logic    accept;
    t_result slot_res;
    logic    r_out_valid;
    t_result r_out;

    // configuration register
    mcsf_apb_regs u_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_ack_check_enable (ack_check)
    );

    // intake whenever the output register is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mcsf_slot_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_ack_check       (ack_check),
        .i_op              (s_axis_tuser),
        .i_expected_sector (s_axis_tdata[15:0]),
        .i_card_byte       (s_axis_tdata[23:16]),
        .i_host_byte       (s_axis_tdata[31:24]),
        .o_result          (slot_res)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= slot_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.status, r_out.data_byte, r_out.send_byte};
    assign m_axis_tuser  = r_out.data_valid;
    assign m_axis_tlast  = r_out.frame_done;

endmodule

`default_nettype wire

### hw/rtl/mcsf_checker.sv
// port-level checker for the memory card sector frame engine, bound to the top level
`default_nettype none

module mcsf_checker
    import mcsf_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    m_axis_tvalid,
    input wire logic                    m_axis_tready,
    input wire logic [OutDataWidth-1:0] m_axis_tdata,
    input wire logic                    m_axis_tuser,
    input wire logic                    m_axis_tlast,
    input wire logic                    pready
);

    // status only reported on the last slot of a frame
    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[18:16] == ST_OK))
        else $error("status set on a slot that is not the last");

    // status codes stay in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18:16] <= ST_UNKNOWN))
        else $error("status code out of range");

    // read data is never flagged on the closing slot
    a_data_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tlast)
        else $error("data flagged on the last slot");

    // apb never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output transaction changed while stalled");

endmodule

bind memory_card_sector_frame mcsf_checker u_mcsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

`default_nettype wire

### bench/tb_memory_card_sector_frame.sv
// self-checking testbench for the memory card sector frame engine
module tb_memory_card_sector_frame;
    import mcsf_pkg::*;

    // card byte faults that a frame can carry
    typedef enum int {
        FLT_NONE,
        FLT_ID,
        FLT_ACK,
        FLT_ECHO,
        FLT_CSUM,
        FLT_END,
        FLT_NOISE
    } t_fault_kind;

    localparam int unsigned QuietLimit = 2000;
    localparam int unsigned RandomSlots = 800;
    localparam logic [ApbAddrWidth-1:0] AckCheckAddr = {RegIdxAckCheck, 2'b00};

    // predicts one result per slot and compares what the engine emits
    class t_sector_frame_tracker;
        t_result     pending_slots[$];
        int unsigned mismatches;
        int unsigned slots_seen;
        int unsigned faulted_frames;
        logic        ack_check;
        logic [7:0]  slot;
        logic        mode;
        logic [15:0] sector_q;
        logic [7:0]  rx_xor;
        logic [7:0]  tx_xor;
        logic [7:0]  echo_hi;
        t_status     first_err;

        function new();
            mismatches = 0;
            slots_seen = 0;
            faulted_frames = 0;
            ack_check = AckCheckReset;
            slot = '0;
            mode = OpRead;
            sector_q = '0;
            rx_xor = '0;
            tx_xor = '0;
            echo_hi = '0;
            first_err = ST_OK;
        endfunction

        function void keep_first(t_status code);
            if (first_err == ST_OK) begin
                first_err = code;
            end
        endfunction

        // advance the frame state by one slot and queue the expected result
        function void note_slot(logic op, logic [15:0] sector, logic [7:0] card,
                                logic [7:0] host);
            t_result    exp_r;
            logic [7:0] pos;
            logic [7:0] last_slot;
            logic [7:0] tx;
            if (slot == SlotCmd) begin
                mode = op;
                sector_q = sector;
                rx_xor = '0;
                tx_xor = '0;
                echo_hi = '0;
                first_err = ST_OK;
            end
            pos = slot;
            last_slot = (mode == OpWrite) ? SlotWrLast : SlotRdLast;
            slots_seen++;

            // byte sent to the card
            tx = 8'h00;
            if (pos == SlotCmd) begin
                tx = ByteCmd;
            end else if (pos == SlotKind) begin
                tx = (mode == OpWrite) ? ByteWrite : ByteRead;
            end else if (pos == SlotSecHi) begin
                tx = sector_q[15:8];
            end else if (pos == SlotSecLo) begin
                tx = sector_q[7:0];
            end else if (mode == OpWrite && pos >= SlotWrDataLo && pos <= SlotWrDataHi) begin
                tx = host;
            end else if (mode == OpWrite && pos == SlotWrCsum) begin
                tx = tx_xor;
            end
            if (mode == OpWrite && pos >= SlotSecHi && pos <= SlotWrDataHi) begin
                tx_xor = tx_xor ^ tx;
            end

            exp_r.send_byte = tx;
            exp_r.data_byte = 8'h00;
            exp_r.data_valid = 1'b0;
            exp_r.frame_done = 1'b0;
            exp_r.status = ST_OK;

            // card identification
            if ((pos == SlotId0 && card != ByteId0) || (pos == SlotId1 && card != ByteId1)) begin
                keep_first(ST_NO_CARD);
            end

            if (mode == OpRead) begin
                if (ack_check && ((pos == SlotRdAck0 && card != ByteAck0) ||
                                  (pos == SlotRdAck1 && card != ByteAck1))) begin
                    keep_first(ST_NO_ACK);
                end
                if (pos >= SlotRdEchoHi && pos <= SlotRdCsum) begin
                    rx_xor = rx_xor ^ card;
                end
                if (pos == SlotRdEchoHi) begin
                    echo_hi = card;
                end
                if (pos == SlotRdEchoLo && {echo_hi, card} != sector_q) begin
                    keep_first(ST_BAD_SEC);
                end
                if (pos >= SlotRdDataLo && pos <= SlotRdDataHi) begin
                    exp_r.data_byte = card;
                    exp_r.data_valid = 1'b1;
                end
                if (pos == SlotRdCsum && rx_xor != 8'h00) begin
                    keep_first(ST_BAD_CSUM);
                end
                if (pos == SlotRdLast && card != ByteGood) begin
                    keep_first(ST_UNKNOWN);
                end
            end else begin
                if (ack_check && ((pos == SlotWrAck0 && card != ByteAck0) ||
                                  (pos == SlotWrAck1 && card != ByteAck1))) begin
                    keep_first(ST_NO_ACK);
                end
                if (pos == SlotWrLast) begin
                    if (card == ByteBadCsum) begin
                        keep_first(ST_BAD_CSUM);
                    end else if (card == ByteBadSec) begin
                        keep_first(ST_BAD_SEC);
                    end else if (card != ByteGood) begin
                        keep_first(ST_UNKNOWN);
                    end
                end
            end

            // end of frame reports the first error
            if (pos >= last_slot) begin
                exp_r.frame_done = 1'b1;
                exp_r.status = first_err;
                slot = '0;
            end else begin
                slot = pos + 8'd1;
            end
            pending_slots.push_back(exp_r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                mismatches++;
                $display("%0t: mismatch on %s, expected %0h, actual %0h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_slot(t_result got);
            t_result exp_r;
            if (pending_slots.size() == 0) begin
                mismatches++;
                $display("%0t: result with no slot pending, actual %0h", $time, got);
            end else begin
                exp_r = pending_slots.pop_front();
                if (exp_r.frame_done && exp_r.status != ST_OK) begin
                    faulted_frames++;
                end
                compare_field("send_byte", exp_r.send_byte, got.send_byte);
                compare_field("data_byte", exp_r.data_byte, got.data_byte);
                compare_field("data_valid", exp_r.data_valid, got.data_valid);
                compare_field("frame_done", exp_r.frame_done, got.frame_done);
                compare_field("status", exp_r.status, got.status);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata;   // [15:0] expected_sector, [23:16] card_byte,
                                             // [31:24] host_byte
    logic                    s_axis_tuser;   // [0] op
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OutDataWidth-1:0] m_axis_tdata;   // [7:0] send_byte, [15:8] data_byte,
                                             // [18:16] status, [23:19] zero
    logic                    m_axis_tuser;   // [0] data_valid
    logic                    m_axis_tlast;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ApbAddrWidth-1:0] paddr;
    logic [ApbDataWidth-1:0] pwdata;
    logic [ApbDataWidth-1:0] prdata;
    logic                    pready;

    t_sector_frame_tracker tracker;
    int unsigned send_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned quiet_cycles = 0;
    int unsigned bench_errors = 0;
    int unsigned read_frames = 0;
    int unsigned write_frames = 0;

    memory_card_sector_frame dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // sample both streams mid-cycle, where every signal has settled
    always @(negedge i_clk) begin : monitor
        t_result got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.send_byte = m_axis_tdata[7:0];
            got.data_byte = m_axis_tdata[15:8];
            got.status = t_status'(m_axis_tdata[18:16]);
            got.data_valid = m_axis_tuser;
            got.frame_done = m_axis_tlast;
            tracker.check_slot(got);
        end
        if (s_axis_tvalid && s_axis_tready) begin
            tracker.note_slot(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
                              s_axis_tdata[31:24]);
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    // watchdog on a stalled handshake
    initial begin
        while (quiet_cycles < QuietLimit) @(negedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("status: fail");
        $finish;
    end

    // one apb transfer, setup then access
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        logic taken;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= AckCheckAddr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdata = prdata;
            taken = pready;
            @(posedge i_clk);
        end while (!taken);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the ack check register and read it back
    task automatic set_ack_check(input logic ack);
        logic [31:0] rdata;
        apb_access(1'b1, {31'd0, ack}, rdata);
        tracker.ack_check = ack;
        @(posedge i_clk);
        apb_access(1'b0, 32'd0, rdata);
        if (rdata[0] !== ack) begin
            bench_errors++;
            $display("%0t: mismatch on ack_check_enable read, expected %0h, actual %0h",
                     $time, ack, rdata[0]);
        end
    endtask

    // one slot on the input stream, after a random gap
    task automatic send_slot(input logic op, input logic [15:0] sector, input logic [7:0] card,
                             input logic [7:0] host);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {host, card, sector};
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_slots.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // build the card side of a whole frame, inject faults, send every slot
    task automatic run_frame(input logic op, input logic [15:0] sector, input t_fault_kind fa,
                             input t_fault_kind fb, input logic extremes);
        logic [7:0]  card [0:139];
        logic [7:0]  host [0:139];
        logic [7:0]  sum;
        logic [7:0]  flip;
        logic [7:0]  v;
        logic        csum_bad;
        int          last_slot;
        t_fault_kind kind;
        last_slot = (op == OpWrite) ? SlotWrLast : SlotRdLast;
        csum_bad = 1'b0;
        flip = 8'h00;
        for (int i = 0; i <= last_slot; i++) begin
            card[i] = extremes ? {8{i[0]}} : 8'($urandom);
            host[i] = extremes ? {8{~i[0]}} : 8'($urandom);
        end
        card[SlotId0] = ByteId0;
        card[SlotId1] = ByteId1;
        if (op == OpRead) begin
            card[SlotRdAck0] = ByteAck0;
            card[SlotRdAck1] = ByteAck1;
            card[SlotRdEchoHi] = sector[15:8];
            card[SlotRdEchoLo] = sector[7:0];
            card[SlotRdLast] = ByteGood;
        end else begin
            card[SlotWrAck0] = ByteAck0;
            card[SlotWrAck1] = ByteAck1;
            card[SlotWrLast] = ByteGood;
        end

        for (int k = 0; k < 2; k++) begin
            kind = (k == 0) ? fa : fb;
            flip = 8'($urandom_range(255, 1));
            case (kind)
                FLT_ID: begin
                    card[$urandom_range(1) ? SlotId1 : SlotId0] ^= flip;
                end
                FLT_ACK: begin
                    if (op == OpRead) begin
                        card[$urandom_range(1) ? SlotRdAck1 : SlotRdAck0] ^= flip;
                    end else begin
                        card[$urandom_range(1) ? SlotWrAck1 : SlotWrAck0] ^= flip;
                    end
                end
                FLT_ECHO: begin
                    if (op == OpRead) begin
                        card[$urandom_range(1) ? SlotRdEchoLo : SlotRdEchoHi] ^= flip;
                    end else begin
                        card[SlotWrLast] = ByteBadSec;
                    end
                end
                FLT_CSUM: begin
                    if (op == OpRead) begin
                        csum_bad = 1'b1;
                    end else begin
                        card[SlotWrLast] = ByteBadCsum;
                    end
                end
                FLT_END: begin
                    if (op == OpRead) begin
                        card[SlotRdLast] ^= flip;
                    end else begin
                        do v = 8'($urandom);
                        while (v == ByteGood || v == ByteBadCsum || v == ByteBadSec);
                        card[SlotWrLast] = v;
                    end
                end
                FLT_NOISE: begin
                    card[$urandom_range(last_slot)] = 8'($urandom);
                end
                default: begin
                end
            endcase
        end

        // read checksum byte closes the xor over echo and data
        if (op == OpRead) begin
            sum = 8'h00;
            for (int i = SlotRdEchoHi; i <= SlotRdDataHi; i++) begin
                sum ^= card[i];
            end
            card[SlotRdCsum] = csum_bad ? (sum ^ flip) : sum;
            if (csum_bad && flip == 8'h00) begin
                card[SlotRdCsum] = ~sum;
            end
            read_frames++;
        end else begin
            write_frames++;
        end

        // op and sector only count at slot 0
        for (int i = 0; i <= last_slot; i++) begin
            send_slot((i == 0) ? op : 1'($urandom), (i == 0) ? sector : 16'($urandom),
                      card[i], host[i]);
        end
    endtask

    initial begin
        int unsigned random_slots;
        int unsigned phase;
        logic        op;
        logic [15:0] sector;
        t_fault_kind fb;
        tracker = new();
        random_slots = 0;
        phase = 0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clean read and write at the sector extremes, then a bad ack ignored
        set_ack_check(AckCheckReset);
        run_frame(OpRead, 16'h0000, FLT_NONE, FLT_NONE, 1'b1);
        run_frame(OpWrite, 16'hFFFF, FLT_NONE, FLT_NONE, 1'b1);
        drain_results();
        set_ack_check(~AckCheckReset);
        run_frame(OpRead, 16'h8001, FLT_ACK, FLT_NONE, 1'b0);

        // random frames, one idling pattern and register setting per phase
        while (random_slots < RandomSlots) begin
            drain_results();
            set_ack_check((phase < 2) ? phase[0] : 1'($urandom_range(1)));
            case (phase % 4)
                0: begin
                    send_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 78;
                    sink_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    sink_stall_pct = 78;
                end
                default: begin
                    send_idle_pct = 20;
                    sink_stall_pct = 20;
                end
            endcase
            op = 1'($urandom_range(1));
            if ($urandom_range(3) == 0) begin
                sector = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end else begin
                sector = 16'($urandom);
            end
            fb = ($urandom_range(3) == 0) ? t_fault_kind'($urandom_range(6)) : FLT_NONE;
            run_frame(op, sector, t_fault_kind'(phase % 7), fb, 1'b0);
            random_slots += (op == OpWrite) ? 138 : 140;
            phase++;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("covered %0d slots in %0d read and %0d write frames, %0d ending in error",
                 tracker.slots_seen, read_frames, write_frames, tracker.faulted_frames);
        $display("ack checking exercised on and off, with sender gaps and sink stalls");
        if (tracker.mismatches == 0 && bench_errors == 0 &&
            tracker.pending_slots.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
